@@ rtl/hbac_pkg.sv @@
// Package: shared widths, constants and types for the hydrogen-bond accumulator.
`timescale 1ns / 1ps
package hbac_pkg;

  localparam int unsigned CoordW   = 16;
  localparam int unsigned SqW      = 34;  // sum of three 16-bit squares
  localparam int unsigned LenW     = 17;  // isqrt of SqW bits
  localparam int unsigned AccW     = 48;
  localparam int unsigned CntW     = 32;
  localparam int unsigned CosW     = 16;
  localparam int unsigned TetraW   = 15;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NumW     = 48;  // |dot| * 2^14
  localparam int unsigned DenW     = 34;  // len_cov * len_cand

  localparam logic [CosW-1:0] OneQ14   = 16'd16384;
  localparam logic [CosW-1:0] ThirdQ14 = 16'd5461;

  localparam logic [CfgIdxW-1:0] RegRtwC1  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegRtwC2  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegScwC1  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegScwC2  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegCutoff = 3'd4;

  // Opcodes for the shared iterative unit
  typedef enum logic [1:0] {
    OpSqrt = 2'd0,
    OpDiv  = 2'd1
  } iter_op_e;

  typedef struct packed {
    logic     start;
    iter_op_e op;
  } iter_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } iter_stat_t;

endpackage

@@ rtl/hbac_iter_unit.sv @@
// Shared iterative unit: bit-serial square root and restoring division.
`timescale 1ns / 1ps
module hbac_iter_unit (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  hbac_pkg::iter_ctrl_t     ctrl_i,
  input  logic [hbac_pkg::NumW-1:0] a_i,   // radicand or dividend
  input  logic [hbac_pkg::DenW-1:0] b_i,   // divisor
  output hbac_pkg::iter_stat_t     stat_o,
  output logic [hbac_pkg::NumW-1:0] res_o
);
  import hbac_pkg::*;

  localparam int unsigned StepW = 6;

  logic             busy_q, busy_d, done_q, done_d;
  iter_op_e         op_q, op_d;
  logic [StepW-1:0] step_q, step_d;
  logic [NumW-1:0]  val_q, val_d;    // remaining radicand / dividend bits
  logic [NumW-1:0]  res_q, res_d;    // root or quotient
  logic [NumW:0]    rem_q, rem_d;    // partial remainder
  logic [DenW-1:0]  den_q, den_d;

  logic [NumW:0] trial;
  logic [NumW:0] sq_rem;
  logic [NumW:0] sq_try;
  logic [NumW:0] dv_rem;

  always_comb begin
    sq_rem = {rem_q[NumW-2:0], val_q[NumW-1:NumW-2]};
    sq_try = {res_q[NumW-2:0], 2'b01};
    dv_rem = {rem_q[NumW-1:0], val_q[NumW-1]};
    trial  = (op_q == OpSqrt) ? sq_rem - sq_try
                              : dv_rem - {{(NumW+1-DenW){1'b0}}, den_q};
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    step_d = step_q;
    val_d  = val_q;
    res_d  = res_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      op_d   = ctrl_i.op;
      val_d  = a_i;
      den_d  = b_i;
      res_d  = '0;
      rem_d  = '0;
      step_d = (ctrl_i.op == OpSqrt) ? StepW'(SqW / 2) : StepW'(NumW);
      if (ctrl_i.op == OpSqrt) val_d = {a_i[SqW-1:0], {(NumW-SqW){1'b0}}};
    end else if (busy_q) begin
      if (op_q == OpSqrt) begin
        val_d = {val_q[NumW-3:0], 2'b00};
        if (!trial[NumW]) begin
          rem_d = trial;
          res_d = {res_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = sq_rem;
          res_d = {res_q[NumW-2:0], 1'b0};
        end
      end else begin
        val_d = {val_q[NumW-2:0], 1'b0};
        if (!trial[NumW]) begin
          rem_d = trial;
          res_d = {res_q[NumW-2:0], 1'b1};
        end else begin
          rem_d = dv_rem;
          res_d = {res_q[NumW-2:0], 1'b0};
        end
      end
      step_d = step_q - StepW'(1);
      if (step_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= OpSqrt;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    res_q <= res_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign res_o  = res_q;

endmodule

@@ rtl/hbac_seq.sv @@
// Sequencer: squares, lengths, cosine, criteria, tetrahedral term and sums.
`timescale 1ns / 1ps
module hbac_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [hbac_pkg::CoordW-1:0] vec_i [6],
  input  logic signed [15:0]           rtw_c1_i,
  input  logic signed [15:0]           rtw_c2_i,
  input  logic signed [15:0]           scw_c1_i,
  input  logic signed [15:0]           scw_c2_i,
  input  logic [14:0]                  cutoff_i,
  output logic                         idle_o,
  output logic                         done_o,
  output logic                         pair_valid_o,
  output logic                         rtw_bonded_o,
  output logic                         scw_bonded_o,
  output logic signed [hbac_pkg::CosW-1:0] cosine_o,
  output logic [hbac_pkg::TetraW-1:0]  tetra_o,
  output logic [hbac_pkg::AccW-1:0]    rtw_sum_o,
  output logic [hbac_pkg::AccW-1:0]    scw_sum_o,
  output logic [hbac_pkg::CntW-1:0]    rtw_cnt_o,
  output logic [hbac_pkg::CntW-1:0]    scw_cnt_o
);
  import hbac_pkg::*;

  typedef enum logic [10:0] {
    StIdle  = 11'b00000000001,
    StSq    = 11'b00000000010,
    StSqrtA = 11'b00000000100,
    StWaitA = 11'b00000001000,
    StSqrtB = 11'b00000010000,
    StWaitB = 11'b00000100000,
    StDiv   = 11'b00001000000,
    StWaitD = 11'b00010000000,
    StCrit  = 11'b00100000000,
    StTetra = 11'b01000000000,
    StAcc   = 11'b10000000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0] k_q;  // square / dot term index

  logic signed [CoordW-1:0] v_q [6];
  logic [SqW-1:0]         sqa_q, sqb_q;
  logic signed [SqW:0]    dot_q;
  logic [LenW-1:0]        la_q, lb_q;
  logic [DenW-1:0]        den_q;
  logic                   valid_q, rtw_q, scw_q;
  logic signed [CosW-1:0] cos_q;
  logic [TetraW-1:0]      tetra_q;
  logic [AccW-1:0]        rsum_q, ssum_q;
  logic [CntW-1:0]        rcnt_q, scnt_q;
  logic signed [32:0]     rhs_r_q, rhs_s_q;

  iter_ctrl_t        ictl;
  iter_stat_t        ist;
  logic [NumW-1:0]   ia, ires;

  hbac_iter_unit u_iter (
    .clk_i (clk_i), .rst_ni (rst_ni), .ctrl_i (ictl),
    .a_i (ia), .b_i (den_q), .stat_o (ist), .res_o (ires)
  );

  // One multiplier a cycle, time-shared by the sequencer
  logic signed [CoordW-1:0] ma, mb;
  logic signed [31:0] prod;
  always_comb begin
    if (k_q < 4'd6) begin
      ma = v_q[3'(k_q)];
      mb = v_q[3'(k_q)];
    end else begin
      ma = v_q[3'(k_q - 4'd6)];
      mb = v_q[3'(k_q - 4'd3)];
    end
    prod = ma * mb;
  end

  logic [NumW-1:0] dot_mag;
  assign dot_mag = dot_q[SqW] ? NumW'(-dot_q) << 14 : NumW'(dot_q) << 14;

  always_comb begin
    ictl    = '{start: 1'b0, op: OpSqrt};
    ia      = {{(NumW-SqW){1'b0}}, sqa_q};
    state_d = state_q;
    case (state_q)
      StIdle:  if (start_i) state_d = StSq;
      StSq:    if (k_q == 4'd8) state_d = StSqrtA;
      StSqrtA: begin
        ictl    = '{start: 1'b1, op: OpSqrt};
        state_d = StWaitA;
      end
      StWaitA: if (ist.done) state_d = StSqrtB;
      StSqrtB: begin
        ictl    = '{start: 1'b1, op: OpSqrt};
        ia      = {{(NumW-SqW){1'b0}}, sqb_q};
        state_d = StWaitB;
      end
      StWaitB: if (ist.done) state_d = StDiv;
      StDiv: begin
        if (valid_q) begin
          ictl    = '{start: 1'b1, op: OpDiv};
          ia      = dot_mag;
          state_d = StWaitD;
        end else begin
          state_d = StAcc;
        end
      end
      StWaitD: if (ist.done) state_d = StCrit;
      StCrit:  state_d = StTetra;
      StTetra: state_d = StAcc;
      StAcc:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  logic [NumW-1:0]        qclamp;
  logic signed [16:0]     cos_nx;
  logic signed [16:0]     tsum;
  logic signed [33:0]     tse;
  logic [33:0]            tsq;
  logic [19:0]            tsh;
  logic signed [47:0]     lhs;
  logic [AccW:0]          radd, sadd;
  assign qclamp = (ires > NumW'(OneQ14)) ? NumW'(OneQ14) : ires;
  assign cos_nx = dot_q[SqW] ? -$signed({2'b00, qclamp[14:0]})
                             : $signed({2'b00, qclamp[14:0]});
  assign tsum   = 17'(cos_q) + 17'(ThirdQ14);
  assign tse    = 34'(tsum);
  assign tsq    = $unsigned(tse * tse) + 34'd8192;
  assign tsh    = 20'(tsq >> 14);
  assign lhs    = 48'($signed({1'b0, lb_q})) <<< 14;
  assign radd   = {1'b0, rsum_q} + {{(AccW-TetraW+1){1'b0}}, tetra_q};
  assign sadd   = {1'b0, ssum_q} + {{(AccW-TetraW+1){1'b0}}, tetra_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
      rsum_q  <= '0;
      ssum_q  <= '0;
      rcnt_q  <= '0;
      scnt_q  <= '0;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == StAcc);
      if (state_q == StIdle) k_q <= '0;
      else if (state_q == StSq) k_q <= k_q + 4'd1;
      if (state_q == StAcc) begin
        if (rtw_q) begin
          rsum_q <= radd[AccW] ? '1 : radd[AccW-1:0];
          if (rcnt_q != '1) rcnt_q <= rcnt_q + CntW'(1);
        end
        if (scw_q) begin
          ssum_q <= sadd[AccW] ? '1 : sadd[AccW-1:0];
          if (scnt_q != '1) scnt_q <= scnt_q + CntW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (start_i) v_q <= vec_i;
        sqa_q <= '0; sqb_q <= '0; dot_q <= '0;
        rtw_q <= 1'b0; scw_q <= 1'b0; cos_q <= '0; tetra_q <= '0;
      end
      StSq: begin
        // terms 0..2 cov squares, 3..5 cand squares, 6..8 dot products
        if (k_q < 4'd3) sqa_q <= sqa_q + SqW'($unsigned(prod));
        else if (k_q < 4'd6) sqb_q <= sqb_q + SqW'($unsigned(prod));
        else dot_q <= dot_q + (SqW+1)'(prod);
      end
      StWaitA: if (ist.done) la_q <= ires[LenW-1:0];
      StWaitB: if (ist.done) begin
        lb_q  <= ires[LenW-1:0];
        den_q <= DenW'(la_q) * DenW'(ires[LenW-1:0]);
        valid_q <= (la_q != '0) && (ires[LenW-1:0] != '0) &&
                   (la_q <= LenW'(cutoff_i)) && (ires[LenW-1:0] > LenW'(cutoff_i));
      end
      StWaitD: if (ist.done) begin
        cos_q   <= cos_nx[CosW-1:0];
        rhs_r_q <= 33'(rtw_c2_i) * 33'(cos_nx);
        rhs_s_q <= 33'(scw_c2_i) * 33'(cos_nx);
      end
      StCrit: begin
        rtw_q <= lhs < (48'(rtw_c1_i) <<< 14) + 48'(rhs_r_q);
        scw_q <= lhs < (48'(scw_c1_i) <<< 14) + 48'(rhs_s_q);
        tetra_q <= (tsh > 20'd32767) ? 15'h7FFF : tsh[TetraW-1:0];
      end
      default: ;
    endcase
  end

  assign idle_o       = (state_q == StIdle);
  assign pair_valid_o = valid_q;
  assign rtw_bonded_o = rtw_q;
  assign scw_bonded_o = scw_q;
  assign cosine_o     = cos_q;
  assign tetra_o      = tetra_q;
  assign rtw_sum_o    = rsum_q;
  assign scw_sum_o    = ssum_q;
  assign rtw_cnt_o    = rcnt_q;
  assign scw_cnt_o    = scnt_q;

endmodule

@@ rtl/hbond_angle_criterion_accumulator_top.sv @@
// Top level: stream ports, configuration registers and output register.
`timescale 1ns / 1ps
// After a valid candidate pair is accepted, its result passes through nine
// multiply-accumulate steps, two 17-step square roots and a 48-step division
// on one shared bit-serial unit (each with a start and a done cycle), then criterion,
// tetrahedral term, accumulate and output register steps. An invalid pair skips the
// division, criterion and tetrahedral steps. The input is not ready while a pair is in
// work or its result waits; a new pair is taken once it is taken.
module hbond_angle_criterion_accumulator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,   // cov_x, cov_y, cov_z, cand_x, cand_y, cand_z
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [207:0] m_axis_tdata,   // pair_valid, rtw_bonded, scw_bonded,
                                       // cosine_q14, tetra_term, rtw_total,
                                       // scw_total, rtw_samples, scw_samples, pad
  input  logic         cfg_we_i,
  input  logic [hbac_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [hbac_pkg::CfgDataW-1:0] cfg_data_i
);
  import hbac_pkg::*;

  logic signed [15:0] rtw_c1_q, rtw_c2_q, scw_c1_q, scw_c2_q;
  logic [14:0] cutoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rtw_c1_q <= 16'sd1403;
      rtw_c2_q <= -16'sd1751;
      scw_c1_q <= 16'sd1792;
      scw_c2_q <= -16'sd1792;
      cutoff_q <= 15'd1331;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegRtwC1:  rtw_c1_q <= cfg_data_i;
        RegRtwC2:  rtw_c2_q <= cfg_data_i;
        RegScwC1:  scw_c1_q <= cfg_data_i;
        RegScwC2:  scw_c2_q <= cfg_data_i;
        RegCutoff: cutoff_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic signed [CoordW-1:0] vec [6];
  always_comb begin
    for (int i = 0; i < 6; i++) vec[i] = s_axis_tdata[16*i +: 16];
  end

  logic idle, done, pv, rb, sb;
  logic signed [CosW-1:0] cosv;
  logic [TetraW-1:0] tet;
  logic [AccW-1:0] rs, ss;
  logic [CntW-1:0] rc, sc;
  logic out_vld_q;
  logic [207:0] out_q;

  // Hold off while busy, while a result waits, and in the cycle the result is loaded into the output register
  assign s_axis_tready = idle && !out_vld_q && !done;

  hbac_seq u_seq (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .start_i (s_axis_tvalid && s_axis_tready), .vec_i (vec),
    .rtw_c1_i (rtw_c1_q), .rtw_c2_i (rtw_c2_q),
    .scw_c1_i (scw_c1_q), .scw_c2_i (scw_c2_q), .cutoff_i (cutoff_q),
    .idle_o (idle), .done_o (done), .pair_valid_o (pv),
    .rtw_bonded_o (rb), .scw_bonded_o (sb), .cosine_o (cosv), .tetra_o (tet),
    .rtw_sum_o (rs), .scw_sum_o (ss), .rtw_cnt_o (rc), .scw_cnt_o (sc)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (done) out_vld_q <= 1'b1;
    else if (m_axis_tready) out_vld_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (done) out_q <= {14'd0, sc, rc, ss, rs, tet, cosv, sb, rb, pv};
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ rtl/hbac_checker.sv @@
// Port-level checker for the accumulator, bound to the top level.
`timescale 1ns / 1ps
module hbac_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [207:0] m_axis_tdata
);
  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input ready while result pending");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after a transaction");
  a_bond_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[2:1] == 2'b00)
    else $error("bond flag on invalid pair");
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[207:194] == 14'd0) else $error("pad bits set");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
endmodule

bind hbond_angle_criterion_accumulator_top hbac_checker u_hbac_checker (.*);
